FILE: hdl/bfv_pkg.sv
// Shared types and constants for the ballistic firing vector pipeline.
// Used by bfv_grav_div and the top level ballistic_firing_vector_unit.
package bfv_pkg;

  localparam int unsigned IN_TDATA_W  = 104;
  localparam int unsigned OUT_TDATA_W = 16;
  localparam int unsigned DIVIDEND_W  = 12;
  localparam int unsigned DIVISOR_W   = 6;
  localparam int unsigned GRAV_W      = 8;
  localparam int unsigned DIV_SPLIT   = 6;

  typedef logic [7:0] byte_t;

  // Angle mask XORed in per octant, indexed by {ny >= 0, nx >= 0, x major}.
  localparam byte_t OCTANT_MASK [8] = '{
    8'hbf, 8'h80, 8'hc0, 8'hff, 8'h40, 8'h7f, 8'h3f, 8'h00
  };

endpackage

FILE: hdl/bfv_grav_div.sv
// Two-stage pipelined restoring divider for the gravity term.
// Depends on bfv_pkg for widths; advances on the shared pipeline enable.
module bfv_grav_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [bfv_pkg::DIVIDEND_W-1:0]  dividend,
  input  logic [bfv_pkg::DIVISOR_W-1:0]   divisor,
  output logic [bfv_pkg::GRAV_W-1:0]      quot
);

  localparam int unsigned RW = bfv_pkg::DIVISOR_W + 1;
  localparam int unsigned HI = bfv_pkg::DIVIDEND_W - bfv_pkg::DIV_SPLIT;

  logic [RW-1:0]                     rem_a_r, rem_a_nxt;
  logic [bfv_pkg::DIVIDEND_W-1:0]    q_a_r, q_a_nxt;
  logic [bfv_pkg::DIVISOR_W-1:0]     d_a_r;
  logic [bfv_pkg::DIVIDEND_W-1:0]    dd_a_r;
  logic [bfv_pkg::DIVIDEND_W-1:0]    q_b_r, q_b_nxt;

  // First half: upper quotient bits.
  always_comb begin
    logic [RW-1:0] r;
    r = '0;
    q_a_nxt = '0;
    for (int i = bfv_pkg::DIVIDEND_W - 1; i >= int'(HI); i--) begin
      r = {r[RW-2:0], dividend[i]};
      if (r >= {1'b0, divisor}) begin
        r = r - {1'b0, divisor};
        q_a_nxt[i] = 1'b1;
      end
    end
    rem_a_nxt = r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_a_r <= rem_a_nxt;
      q_a_r   <= q_a_nxt;
      d_a_r   <= divisor;
      dd_a_r  <= dividend;
    end
  end

  // Second half: lower quotient bits.
  always_comb begin
    logic [RW-1:0] r;
    r = rem_a_r;
    q_b_nxt = q_a_r;
    for (int i = int'(HI) - 1; i >= 0; i--) begin
      r = {r[RW-2:0], dd_a_r[i]};
      if (r >= {1'b0, d_a_r}) begin
        r = r - {1'b0, d_a_r};
        q_b_nxt[i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_b_r <= q_b_nxt;
    end
  end

  assign quot = q_b_r[bfv_pkg::GRAV_W-1:0];

endmodule

FILE: hdl/ballistic_firing_vector_unit.sv
// Throughput: one request per cycle; five register stages all advance together
// whenever the output register is empty or its result is being taken.
// Reset: rst_n (synchronous, active low) clears every stage valid bit; the datapath
// registers hold no reset. Depends on bfv_pkg and bfv_grav_div.
module ballistic_firing_vector_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // From bit 0: shooter_pos_x(16) shooter_pos_y(16) shooter_width(4) shooter_height(6)
  // target_pos_x(16) target_pos_y(16) target_width(4) target_height(6)
  // target_speed_x(8) fire_speed_x4(8), zero fill to 104 bits.
  input  logic [bfv_pkg::IN_TDATA_W-1:0]     in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // From bit 0: shot_vel_x(8) shot_vel_y(8).
  output logic [bfv_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // Bit 0: shot_ok.
  output logic                               out_tuser
);

  // One enable for the whole pipe: every stage moves when the output can move.
  logic en;
  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  logic v1_r, v2_r, v3_r, v4_r, v5_r;

  // Stage 1: sprite centres, deltas, shift amount and the range checks.
  logic [16:0] sx, sy, tx, ty;
  logic signed [17:0] dx, dy;
  logic [16:0] adx, ady, big;
  logic [2:0] s_nxt;
  logic fail1_nxt;

  assign sx = {1'b0, in_tdata[15:0]}  + {10'd0, in_tdata[35:32], 3'd0};
  assign sy = {1'b0, in_tdata[31:16]} + {9'd0, in_tdata[41:36], 2'd0};
  assign tx = {1'b0, in_tdata[57:42]} + {10'd0, in_tdata[77:74], 3'd0};
  assign ty = {1'b0, in_tdata[73:58]} + {9'd0, in_tdata[83:78], 2'd0};
  assign dx = $signed({1'b0, tx}) - $signed({1'b0, sx});
  assign dy = $signed({1'b0, ty}) - $signed({1'b0, sy});
  assign adx = dx[17] ? 17'(-dx) : dx[16:0];
  assign ady = dy[17] ? 17'(-dy) : dy[16:0];
  assign big = (adx > ady) ? adx : ady;

  // The shift is one more than the bit length of the whole-tile count; a
  // distance of 4096 or more would need six or more and is out of range.
  always_comb begin
    if (big[11])      s_nxt = 3'd5;
    else if (big[10]) s_nxt = 3'd4;
    else if (big[9])  s_nxt = 3'd3;
    else if (big[8])  s_nxt = 3'd2;
    else              s_nxt = 3'd1;
  end
  assign fail1_nxt = (big == '0) || (big[16:12] != '0);

  logic signed [17:0] dx1_r, dy1_r;
  logic [2:0]  s1_r;
  logic        fail1_r;
  logic [7:0]  lead1_r, x4_1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx1_r   <= dx;
      dy1_r   <= dy;
      s1_r    <= s_nxt;
      fail1_r <= fail1_nxt;
      lead1_r <= in_tdata[91:84];
      x4_1_r  <= in_tdata[99:92];
    end
  end

  // Stage 2: scaled deltas, octant select, divide operands, gravity dividend.
  logic signed [17:0] nx_full, ny_full;
  logic signed [7:0]  nx, ny;
  logic [7:0] anx, any_abs, mag;
  logic x_major;
  logic [5:0] speed;

  assign nx_full = dx1_r >>> s1_r;
  assign ny_full = dy1_r >>> s1_r;
  assign nx = nx_full[7:0];
  assign ny = ny_full[7:0];
  assign anx = nx[7] ? 8'(-nx) : nx;
  assign any_abs = ny[7] ? 8'(-ny) : ny;
  assign x_major = anx >= any_abs;
  assign mag = x_major ? anx : any_abs;
  assign speed = x4_1_r[7:2];

  logic [7:0] num2_r, den2_r, lead2_r, x4_2_r;
  logic [2:0] sel2_r;
  logic [5:0] speed2_r;
  logic       fail2_r;
  logic [bfv_pkg::DIVIDEND_W-1:0] grav_dd2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      num2_r     <= x_major ? any_abs : anx;
      den2_r     <= x_major ? anx : any_abs;
      sel2_r     <= {!ny[7], !nx[7], x_major};
      speed2_r   <= speed;
      fail2_r    <= fail1_r || (speed == '0);
      lead2_r    <= lead1_r;
      x4_2_r     <= x4_1_r;
      grav_dd2_r <= {4'd0, mag} << (s1_r - 3'd1);
    end
  end

  // Gravity quotient comes out of the divider's two register stages, lined up with stage 4.
  logic [bfv_pkg::GRAV_W-1:0] grav;

  bfv_grav_div u_grav_div (
    .clk      (clk),
    .en       (en),
    .dividend (grav_dd2_r),
    .divisor  (speed2_r),
    .quot     (grav)
  );

  // Stage 3: five restoring division steps give the octant-relative angle.
  logic [7:0] ang_nxt;

  always_comb begin
    logic [8:0] twice;
    logic [7:0] num;
    logic [4:0] q;
    num = num2_r;
    q = '0;
    for (int i = 4; i >= 0; i--) begin
      twice = {num, 1'b0};
      if (twice >= {1'b0, den2_r}) begin
        twice = twice - {1'b0, den2_r};
        q[i] = 1'b1;
      end
      num = twice[7:0];
    end
    ang_nxt = {3'd0, q} ^ bfv_pkg::OCTANT_MASK[sel2_r];
  end

  logic [7:0] ang3_r, lead3_r, x4_3_r;
  logic [5:0] speed3_r;
  logic       fail3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      ang3_r   <= ang_nxt;
      speed3_r <= speed2_r;
      fail3_r  <= fail2_r;
      lead3_r  <= lead2_r;
      x4_3_r   <= x4_2_r;
    end
  end

  // Stage 4: piecewise-linear velocity from quadrant and angle within it.
  logic [5:0]  rel, ar, br;
  logic [11:0] a_prod, b_prod;
  logic [5:0]  a_mag, b_mag;
  logic signed [8:0] a_s, b_s, vx_nxt, vy_nxt;

  assign rel = ang3_r[5:0];
  assign ar = (rel <= 6'd32) ? rel : 6'd32;
  assign br = (rel >= 6'd32) ? 6'(7'd64 - {1'b0, rel}) : 6'd32;
  assign a_prod = ar * speed3_r;
  assign b_prod = br * speed3_r;
  assign a_mag = a_prod[10:5];
  assign b_mag = b_prod[10:5];
  assign a_s = $signed({3'd0, a_mag});
  assign b_s = $signed({3'd0, b_mag});

  always_comb begin
    case (ang3_r[7:6])
      2'd0: begin
        vx_nxt = b_s;
        vy_nxt = a_s;
      end
      2'd1: begin
        vx_nxt = -a_s;
        vy_nxt = b_s;
      end
      2'd2: begin
        vx_nxt = -b_s;
        vy_nxt = -a_s;
      end
      default: begin
        vx_nxt = a_s;
        vy_nxt = -b_s;
      end
    endcase
  end

  logic signed [8:0] vx4_r, vy4_r;
  logic [7:0] lead4_r, x4_4_r;
  logic       fail4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vx4_r   <= vx_nxt;
      vy4_r   <= vy_nxt;
      lead4_r <= lead3_r;
      x4_4_r  <= x4_3_r;
      fail4_r <= fail3_r;
    end
  end

  // Stage 5: gravity compensation, leading with saturation, and the range and speed checks.
  logic signed [9:0] vy_g, vx_l;
  logic signed [7:0] vx_sat, vy_fin;
  logic [7:0] avx, avy, amax;
  logic       ok_nxt;

  assign vy_g = $signed({vy4_r[8], vy4_r}) - $signed({2'd0, grav});
  assign vx_l = $signed({vx4_r[8], vx4_r}) + $signed({{2{lead4_r[7]}}, lead4_r});
  assign vx_sat = (vx_l > 10'sd127) ? 8'sd127 :
                  (vx_l < -10'sd128) ? -8'sd128 : vx_l[7:0];
  assign vy_fin = vy_g[7:0];
  assign avx = vx_sat[7] ? 8'(-vx_sat) : vx_sat;
  assign avy = vy_fin[7] ? 8'(-vy_fin) : vy_fin;
  assign amax = (avx > avy) ? avx : avy;
  assign ok_nxt = !fail4_r && (vy_g >= -10'sd128) && (vy_g <= 10'sd127)
                  && (amax <= x4_4_r);

  logic [bfv_pkg::OUT_TDATA_W-1:0] out_data_r;
  logic                            out_ok_r;

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= ok_nxt ? {vy_fin, vx_sat} : '0;
      out_ok_r   <= ok_nxt;
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_tvalid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_ok_r;

`ifndef SYNTHESIS
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("failed request carries a nonzero vector");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> v1_r)
    else $error("accepted request lost at stage 1");

  a_reach_out: assert property (@(posedge clk) disable iff (!rst_n)
    (v4_r && en) |=> out_tvalid)
    else $error("stage 4 request did not reach the output");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && !en) |=> v2_r)
    else $error("stalled stage 2 request dropped");
`endif

endmodule

FILE: verif/ballistic_firing_vector_checker.sv
// Checker for the ballistic firing vector unit: it predicts each aim result from the
// request seen on the input channel and compares it with the output channel.
// Depends on bfv_pkg for the tdata widths.
`timescale 1ns / 100ps

module ballistic_firing_vector_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [bfv_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [bfv_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic                            out_tuser,
  output int                              fail_count,
  output int                              pending_shots,
  output int                              shots_checked,
  output int                              hits_seen
);

  typedef struct packed {
    logic [7:0] vel_y;
    logic [7:0] vel_x;
    logic       ok;
  } shot_t;

  localparam logic [7:0] OCT_MASK [8] = '{
    8'hbf, 8'h80, 8'hc0, 8'hff, 8'h40, 8'h7f, 8'h3f, 8'h00
  };

  shot_t shot_queue[$];

  function automatic int floor_shr(int v, int s);
    return v >>> s;
  endfunction

  function automatic logic [7:0] aim_angle(int nx, int ny);
    logic [7:0] ax, ay, num, den, q;
    logic [8:0] twice;
    logic       x_major, ge, top;
    logic [2:0] sel;
    ax = (nx < 0) ? -nx : nx;
    ay = (ny < 0) ? -ny : ny;
    x_major = ax >= ay;
    sel = {ny >= 0, nx >= 0, x_major};
    num = x_major ? ay : ax;
    den = x_major ? ax : ay;
    q = 8'h08;
    for (int it = 0; it < 16; it++) begin
      twice = {num, 1'b0};
      ge = twice >= {1'b0, den};
      top = q[7];
      num = ge ? 8'(twice - den) : twice[7:0];
      q = {q[6:0], ge};
      if (top) break;
    end
    return q ^ OCT_MASK[sel];
  endfunction

  function automatic shot_t predict_shot(logic [103:0] d);
    shot_t r;
    int sx, sy, tx, ty, lead, x4, dx, dy, big, nx, ny, mag, s, speed;
    int rel, ar, br, a, b, vx, vy, grav, avx, avy;
    logic [7:0] ang;
    logic [1:0] quad;
    r = '0;
    sx = d[15:0] + d[35:32] * 8;
    sy = d[31:16] + d[41:36] * 4;
    tx = d[57:42] + d[77:74] * 8;
    ty = d[73:58] + d[83:78] * 4;
    lead = $signed(d[91:84]);
    x4 = d[99:92];
    dx = tx - sx;
    dy = ty - sy;
    big = ((dx < 0) ? -dx : dx) > ((dy < 0) ? -dy : dy) ? ((dx < 0) ? -dx : dx)
                                                      : ((dy < 0) ? -dy : dy);
    if (big == 0) return r;
    s = 1;
    for (int t = big >> 8; t != 0; t = t >> 1) s++;
    if (s >= 6) return r;
    nx = floor_shr(dx, s);
    ny = floor_shr(dy, s);
    ang = aim_angle(nx, ny);
    mag = (((nx < 0) ? -nx : nx) > ((ny < 0) ? -ny : ny) ? ((nx < 0) ? -nx : nx)
                                                        : ((ny < 0) ? -ny : ny)) & 255;
    speed = x4 >> 2;
    if (speed == 0) return r;
    quad = ang[7:6];
    rel = ang[5:0];
    ar = (rel <= 32) ? rel : 32;
    br = ((64 - rel) <= 32) ? 64 - rel : 32;
    a = ar * speed / 32;
    b = br * speed / 32;
    case (quad)
      2'd0: begin vx = b; vy = a; end
      2'd1: begin vx = -a; vy = b; end
      2'd2: begin vx = -b; vy = -a; end
      default: begin vx = a; vy = -b; end
    endcase
    grav = ((mag << (s - 1)) / speed) & 255;
    vy = vy - grav;
    if (vy < -128 || vy > 127) return r;
    vx = vx + lead;
    if (vx > 127) vx = 127;
    if (vx < -128) vx = -128;
    avx = (vx < 0) ? -vx : vx;
    avy = (vy < 0) ? -vy : vy;
    if ((avx > avy ? avx : avy) > x4) return r;
    r.vel_x = 8'(vx);
    r.vel_y = 8'(vy);
    r.ok = 1'b1;
    return r;
  endfunction

  always @(posedge clk) begin
    shot_t want, got;
    if (!rst_n) begin
      fail_count <= 0;
      shots_checked <= 0;
      hits_seen <= 0;
      pending_shots <= 0;
      shot_queue.delete();
    end else begin
      if (in_tvalid && in_tready) shot_queue = {shot_queue, predict_shot(in_tdata)};
      if (out_tvalid && out_tready) begin
        got = '{vel_y: out_tdata[15:8], vel_x: out_tdata[7:0], ok: out_tuser};
        shots_checked <= shots_checked + 1;
        if (got.ok) hits_seen <= hits_seen + 1;
        if (shot_queue.size() == 0) begin
          if (fail_count < 10) $display("ERROR: unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          want = shot_queue.pop_front();
          if (want !== got) begin
            if (fail_count < 10)
              $display("ERROR: vx %0d/%0d vy %0d/%0d ok %0d/%0d (expected/actual)",
                       $signed(want.vel_x), $signed(got.vel_x), $signed(want.vel_y),
                       $signed(got.vel_y), want.ok, got.ok);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending_shots <= shot_queue.size();
    end
  end

endmodule

FILE: verif/ballistic_firing_vector_unit_tb.sv
// Top of the ballistic firing vector testbench: clock, reset, request stimulus and
// verdict. Depends on bfv_pkg, ballistic_firing_vector_unit and the checker module.
`timescale 1ns / 100ps

module ballistic_firing_vector_unit_tb;

  logic clk, rst_n;
  logic in_tvalid, in_tready, out_tvalid, out_tready, out_tuser;
  logic [bfv_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [bfv_pkg::OUT_TDATA_W-1:0] out_tdata;
  int fail_count, pending_shots, shots_checked, hits_seen;
  int send_idle_pct, recv_stall_pct;
  bit long_hold;
  int idle_cycles;

  ballistic_firing_vector_unit u_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  ballistic_firing_vector_checker u_chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .fail_count, .pending_shots, .shots_checked, .hits_seen
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // The receiver stalls at random, or holds off completely during a long hold.
  initial out_tready = 1'b0;
  always @(posedge clk) begin
    if (!rst_n || long_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // The watchdog counts cycles in which no request and no result moves.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || long_hold) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 2000) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Packs one aim request into tdata, fields from bit 0 in port order.
  function automatic logic [103:0] pack_aim(logic [15:0] spx, logic [15:0] spy,
      logic [3:0] sw, logic [5:0] sh, logic [15:0] tpx, logic [15:0] tpy,
      logic [3:0] tw, logic [5:0] th, logic [7:0] lead, logic [7:0] x4);
    return {4'b0, x4, lead, th, tw, tpy, tpx, sh, sw, spy, spx};
  endfunction

  // Random request: mostly targets within reach so that real vectors come out.
  function automatic logic [103:0] random_aim();
    logic [15:0] spx, spy, tpx, tpy;
    int reach;
    spx = 16'($urandom);
    spy = 16'($urandom);
    case ($urandom_range(9))
      0: reach = 65535;
      1: reach = 8;
      2, 3: reach = 2000;
      default: reach = 400;
    endcase
    tpx = spx + 16'($urandom_range(2 * reach) - reach);
    tpy = spy + 16'($urandom_range(2 * reach) - reach);
    if (reach == 65535) begin
      tpx = 16'($urandom);
      tpy = 16'($urandom);
    end
    return pack_aim(spx, spy, 4'($urandom), 6'($urandom), tpx, tpy, 4'($urandom),
                    6'($urandom), 8'($urandom),
                    ($urandom_range(7) == 0) ? 8'($urandom_range(3)) : 8'($urandom));
  endfunction

  // Offers one request, idling at random first, and waits until it is taken.
  task automatic send_aim(logic [103:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain_shots();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_shots != 0) @(posedge clk);
  endtask

  initial begin
    in_tvalid = 1'b0;
    in_tdata = '0;
    long_hold = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    idle_cycles = 0;
    rst_n = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests: coincident centres, too far, zero speed, divide by zero
    // in the angle, every octant, leading saturation both ways, and the field extremes.
    send_aim(pack_aim(100, 100, 0, 0, 100, 100, 0, 0, 0, 40));
    send_aim(pack_aim(0, 0, 15, 63, 0, 0, 15, 63, 8'h80, 8'hff));
    send_aim(pack_aim(0, 0, 0, 0, 16'hffff, 16'hffff, 15, 63, 8'h7f, 8'hff));
    send_aim(pack_aim(16'hffff, 16'hffff, 15, 63, 0, 0, 0, 0, 8'h80, 8'hff));
    send_aim(pack_aim(1000, 1000, 0, 0, 1100, 1050, 0, 0, 0, 3));
    send_aim(pack_aim(1000, 1000, 0, 0, 1001, 1000, 0, 0, 0, 200));
    send_aim(pack_aim(1000, 1000, 0, 0, 1000, 999, 0, 0, 0, 200));
    send_aim(pack_aim(1000, 1000, 0, 0, 1000 + 7936, 1000, 0, 0, 0, 255));
    send_aim(pack_aim(1000, 1000, 0, 0, 1000 + 7935, 1000, 0, 0, 0, 255));
    for (int oct = 0; oct < 8; oct++)
      send_aim(pack_aim(5000, 5000, 0, 0, 16'(5000 + (oct[0] ? 300 : 120) * (oct[1] ? 1 : -1)),
               16'(5000 + (oct[0] ? 120 : 300) * (oct[2] ? 1 : -1)), 0, 0, 0, 180));
    send_aim(pack_aim(2000, 2000, 0, 0, 2200, 2010, 0, 0, 8'h7f, 200));
    send_aim(pack_aim(2000, 2000, 0, 0, 1800, 2010, 0, 0, 8'h80, 200));
    send_aim(pack_aim(2000, 2000, 0, 0, 2100, 2600, 0, 0, 0, 20));
    drain_shots();

    // Random phases with different idling on each side.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = (ph == 1) ? 48 : (ph == 3) ? 20 : 0;
      recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 20 : 0;
      for (int n = 0; n < 110; n++) send_aim(random_aim());
      drain_shots();
    end

    // Long receiver hold while requests keep coming, so the pipeline backs up.
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        long_hold <= 1'b1;
        repeat (60) @(posedge clk);
        long_hold <= 1'b0;
      end
      for (int n = 0; n < 40; n++) send_aim(random_aim());
    join
    drain_shots();
    repeat (10) @(posedge clk);

    $display("Checked %0d results, %0d of them valid firing vectors.",
             shots_checked, hits_seen);
    if (fail_count == 0 && pending_shots == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: ballistic_firing_vector_unit.f
hdl/bfv_pkg.sv
hdl/bfv_grav_div.sv
hdl/ballistic_firing_vector_unit.sv
verif/ballistic_firing_vector_checker.sv
verif/ballistic_firing_vector_unit_tb.sv
